// ===== design/rlsp_pkg.sv =====
// Shared constants, codes and item types of the round-limited shortest-path block.
`default_nettype none

package rlsp_pkg;

    // Default graph size and field widths.
    localparam int MAX_NODES_DEF = 64;
    localparam int CNT_W         = 9;
    localparam int NODE_COUNT_W  = 7;
    localparam int CMD_W         = 2;
    localparam int NODE_FIELD_W  = 6;
    localparam int WEIGHT_W      = 8;
    localparam int ROUND_W       = 8;
    localparam int STATUS_W      = 2;
    localparam int DIST_W        = 16;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = 7'd64;

    // Sentinel for a missing edge and for an unreached distance.
    localparam logic signed [WEIGHT_W-1:0] NO_EDGE = 8'sd101;
    localparam logic signed [DIST_W-1:0]   NO_DIST = 16'sd101;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNREACH = 2'd2;

    // One request as seen by the sequencer.
    typedef struct packed {
        logic [CMD_W-1:0]           cmd;
        logic [NODE_FIELD_W-1:0]    from_node;
        logic [NODE_FIELD_W-1:0]    to_node;
        logic signed [WEIGHT_W-1:0] edge_weight;
        logic [ROUND_W-1:0]         round_count;
    } t_item;

    // One result.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DIST_W-1:0] distance;
    } t_result;

endpackage

`default_nettype wire

// ===== design/rlsp_intf.sv =====
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface rlsp_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [rlsp_pkg::CMD_W-1:0]            cmd;
    logic [rlsp_pkg::NODE_FIELD_W-1:0]     from_node;
    logic [rlsp_pkg::NODE_FIELD_W-1:0]     to_node;
    logic signed [rlsp_pkg::WEIGHT_W-1:0]  edge_weight;
    logic [rlsp_pkg::ROUND_W-1:0]          round_count;

    modport source (output valid, cmd, from_node, to_node, edge_weight, round_count,
                    input ready);
    modport sink   (input valid, cmd, from_node, to_node, edge_weight, round_count,
                    output ready);
endinterface

interface rlsp_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [rlsp_pkg::STATUS_W-1:0]       status;
    logic signed [rlsp_pkg::DIST_W-1:0]  distance;

    modport source (output valid, status, distance, input ready);
    modport sink   (input valid, status, distance, output ready);
endinterface

`default_nettype wire

// ===== design/rlsp_ram.sv =====
// Synchronous memory with one write port and one registered read port.
`default_nettype none

module rlsp_ram #(
    parameter int ADDR_W = 2 * $clog2(rlsp_pkg::MAX_NODES_DEF),
    parameter int DATA_W = rlsp_pkg::WEIGHT_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [(1 << ADDR_W)];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/rlsp_seq.sv =====
// Command sequencer: edge insert and clear sweep, query init, relaxation rounds, result.
`default_nettype none

module rlsp_seq #(
    parameter int MAX_NODES = rlsp_pkg::MAX_NODES_DEF,
    localparam int NODE_W = $clog2(MAX_NODES),
    localparam int AW     = 2 * NODE_W
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [rlsp_pkg::CNT_W-1:0]   i_node_cnt,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire rlsp_pkg::t_item              i_item,
    // Edge memory ports.
    output logic                              o_edge_we,
    output logic [AW-1:0]                     o_edge_waddr,
    output logic [rlsp_pkg::WEIGHT_W-1:0]     o_edge_wdata,
    output logic                              o_edge_re,
    output logic [AW-1:0]                     o_edge_raddr,
    input  wire logic [rlsp_pkg::WEIGHT_W-1:0] i_edge_rdata,
    // Distance memory ports.
    output logic                              o_dist_we,
    output logic [NODE_W-1:0]                 o_dist_waddr,
    output logic [rlsp_pkg::DIST_W-1:0]       o_dist_wdata,
    output logic                              o_dist_re,
    output logic [NODE_W-1:0]                 o_dist_raddr,
    input  wire logic [rlsp_pkg::DIST_W-1:0]  i_dist_rdata,
    // Result hand-off to the output register.
    input  wire logic                         i_out_free,
    output logic                              o_res_load,
    output rlsp_pkg::t_result                 o_res
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CLEAR  = 8'b0000_0010,
        S_INIT   = 8'b0000_0100,
        S_ROWRD  = 8'b0000_1000,
        S_STREAM = 8'b0001_0000,
        S_DRAIN  = 8'b0010_0000,
        S_FINRD  = 8'b0100_0000,
        S_RESULT = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [NODE_W-1:0] r_i, n_i, r_j, n_j;
    logic [rlsp_pkg::ROUND_W-1:0] r_rounds, n_rounds;
    logic r_s2_vld, n_s2_vld;
    logic r_di_load, n_di_load;
    logic r_absent, n_absent;
    logic signed [rlsp_pkg::DIST_W-1:0] r_di, n_di;
    logic [NODE_W-1:0] r_s2_j, n_s2_j;
    logic [NODE_W-1:0] r_src, n_src, r_dst, n_dst, r_nlast, n_nlast;

    logic accept;
    logic from_ok, to_ok;
    logic signed [rlsp_pkg::WEIGHT_W-1:0] s2_w;
    logic signed [rlsp_pkg::DIST_W-1:0]   s2_dj, s2_cand;
    logic signed [rlsp_pkg::DIST_W:0]     s2_sum;
    logic s2_relax;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign from_ok = rlsp_pkg::CNT_W'(i_item.from_node) < i_node_cnt;
    assign to_ok   = rlsp_pkg::CNT_W'(i_item.to_node) < i_node_cnt;

    // Relaxation of one pair, in the cycle after its reads were issued.
    always_comb begin
        s2_w   = $signed(i_edge_rdata);
        s2_dj  = $signed(i_dist_rdata);
        s2_sum = {r_di[rlsp_pkg::DIST_W-1], r_di}
               + {{(rlsp_pkg::DIST_W + 1 - rlsp_pkg::WEIGHT_W){s2_w[rlsp_pkg::WEIGHT_W-1]}},
                  s2_w};
        // Saturate when the two top bits disagree.
        if (s2_sum[rlsp_pkg::DIST_W] != s2_sum[rlsp_pkg::DIST_W-1]) begin
            s2_cand = s2_sum[rlsp_pkg::DIST_W] ? 16'sh8000 : 16'sh7fff;
        end else begin
            s2_cand = s2_sum[rlsp_pkg::DIST_W-1:0];
        end
        s2_relax = r_s2_vld && (r_di != rlsp_pkg::NO_DIST) && (s2_w != rlsp_pkg::NO_EDGE)
                && ((s2_dj == rlsp_pkg::NO_DIST) || (s2_cand < s2_dj));
    end

    // Next-state and memory port logic.
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_i        = r_i;
        n_j        = r_j;
        n_rounds   = r_rounds;
        n_s2_vld   = 1'b0;
        n_di_load  = 1'b0;
        n_absent   = r_absent;
        n_di       = r_di;
        n_s2_j     = r_s2_j;
        n_src      = r_src;
        n_dst      = r_dst;
        n_nlast    = r_nlast;

        o_edge_we    = 1'b0;
        o_edge_waddr = r_clr_addr;
        o_edge_wdata = rlsp_pkg::NO_EDGE;
        o_edge_re    = 1'b0;
        o_edge_raddr = {r_i, r_j};
        o_dist_we    = 1'b0;
        o_dist_waddr = r_j;
        o_dist_wdata = (r_j == r_src) ? '0 : rlsp_pkg::NO_DIST;
        o_dist_re    = 1'b0;
        o_dist_raddr = r_j;
        o_res_load   = 1'b0;
        o_res.status   = rlsp_pkg::ST_OK;
        o_res.distance = $signed(i_dist_rdata);

        // Stage two writes back an improved distance; a self-loop also moves the row source.
        if (s2_relax) begin
            o_dist_we    = 1'b1;
            o_dist_waddr = r_s2_j;
            o_dist_wdata = s2_cand;
            if (r_s2_j == r_i) begin
                n_di = s2_cand;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_item.cmd)
                        rlsp_pkg::CMD_INSERT: begin
                            o_edge_we    = from_ok && to_ok;
                            o_edge_waddr = {NODE_W'(i_item.from_node), NODE_W'(i_item.to_node)};
                            o_edge_wdata = i_item.edge_weight;
                        end
                        rlsp_pkg::CMD_CLEAR: begin
                            n_clr_addr = '0;
                            n_state    = S_CLEAR;
                        end
                        rlsp_pkg::CMD_QUERY: begin
                            if (from_ok && to_ok) begin
                                n_src    = NODE_W'(i_item.from_node);
                                n_dst    = NODE_W'(i_item.to_node);
                                n_nlast  = NODE_W'(i_node_cnt - rlsp_pkg::CNT_W'(1));
                                n_rounds = i_item.round_count;
                                n_j      = '0;
                                n_state  = S_INIT;
                            end else begin
                                n_absent = 1'b1;
                                n_state  = S_RESULT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                o_edge_we  = 1'b1;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_INIT: begin
                o_dist_we = 1'b1;
                n_j       = r_j + NODE_W'(1);
                if (r_j == r_nlast) begin
                    n_i     = '0;
                    n_state = (r_rounds == '0) ? S_FINRD : S_ROWRD;
                end
            end
            S_ROWRD: begin
                o_dist_re    = 1'b1;
                o_dist_raddr = r_i;
                n_j          = '0;
                n_di_load    = 1'b1;
                n_state      = S_STREAM;
            end
            S_STREAM: begin
                if (r_di_load) begin
                    n_di = $signed(i_dist_rdata);
                end
                o_edge_re = 1'b1;
                o_dist_re = 1'b1;
                n_s2_vld  = 1'b1;
                n_s2_j    = r_j;
                n_j       = r_j + NODE_W'(1);
                if (r_j == r_nlast) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_ROWRD;
                if (r_i == r_nlast) begin
                    n_i = '0;
                    if (r_rounds == rlsp_pkg::ROUND_W'(1)) begin
                        n_state = S_FINRD;
                    end else begin
                        n_rounds = r_rounds - rlsp_pkg::ROUND_W'(1);
                    end
                end else begin
                    n_i = r_i + NODE_W'(1);
                end
            end
            S_FINRD: begin
                o_dist_re    = 1'b1;
                o_dist_raddr = r_dst;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                if (r_absent) begin
                    o_res.status   = rlsp_pkg::ST_ABSENT;
                    o_res.distance = '0;
                end else if ($signed(i_dist_rdata) == rlsp_pkg::NO_DIST) begin
                    o_res.status   = rlsp_pkg::ST_UNREACH;
                    o_res.distance = '0;
                end
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_absent   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the edge clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_rounds   <= '0;
            r_s2_vld   <= 1'b0;
            r_di_load  <= 1'b0;
            r_absent   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_i        <= n_i;
            r_j        <= n_j;
            r_rounds   <= n_rounds;
            r_s2_vld   <= n_s2_vld;
            r_di_load  <= n_di_load;
            r_absent   <= n_absent;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_di    <= n_di;
        r_s2_j  <= n_s2_j;
        r_src   <= n_src;
        r_dst   <= n_dst;
        r_nlast <= n_nlast;
    end

endmodule

`default_nettype wire

// ===== design/round_limited_shortest_path_core.sv =====
// Top level of the round-limited shortest-path block.
//
// Requests arrive on i_req (valid/ready): insert edge, clear all edges, or
// query a distance. Each query gives one result on o_rsp; inserts, clears
// and unknown commands give none. The user must write the node count register
// through i_cfg_we/i_cfg_data only while the block is idle; the block itself
// does not enforce it. An insert writes the edge memory as it is accepted; a
// clear sweeps the whole of it, 4096 entries at the default size, one entry per
// cycle. A query initializes the distance of each of the n active nodes, then
// for each of R rounds and each row reads the row source distance in its own
// state, as the distance memory has a single read port, streams the n pairs
// of the row through relaxation and drains the last write-back, then reads
// the target distance. A query naming an absent node skips to the result.
// Reset (synchronous, active low) clears the node count to 64 and starts the
// same clearing pass over the edge memory; requests are held off until it
// ends. The result sits in an output register, so new requests are taken
// while it waits; a query that finishes while the receiver stalls waits
// until the register is free.
`default_nettype none

module round_limited_shortest_path_core #(
    parameter int MAX_NODES = rlsp_pkg::MAX_NODES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    rlsp_req_if.sink                                 i_req,
    rlsp_rsp_if.source                               o_rsp,
    input  wire logic                                i_cfg_we,
    input  wire logic [rlsp_pkg::NODE_COUNT_W-1:0]   i_cfg_data
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int AW     = 2 * NODE_W;

    logic [rlsp_pkg::NODE_COUNT_W-1:0] r_node_count;
    logic [rlsp_pkg::CNT_W-1:0] node_cnt;
    logic r_ovld;
    rlsp_pkg::t_result r_out;
    rlsp_pkg::t_item item;
    rlsp_pkg::t_result res;
    logic res_load, out_free;

    logic edge_we, edge_re, dist_we, dist_re;
    logic [AW-1:0] edge_waddr, edge_raddr;
    logic [rlsp_pkg::WEIGHT_W-1:0] edge_wdata, edge_rdata;
    logic [NODE_W-1:0] dist_waddr, dist_raddr;
    logic [rlsp_pkg::DIST_W-1:0] dist_wdata, dist_rdata;

    // Node count register and its clamp to the memory size.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= rlsp_pkg::NODE_COUNT_RST;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_data;
        end
    end

    assign node_cnt = (rlsp_pkg::CNT_W'(r_node_count) > rlsp_pkg::CNT_W'(MAX_NODES))
                    ? rlsp_pkg::CNT_W'(MAX_NODES) : rlsp_pkg::CNT_W'(r_node_count);

    // Request fields as one item.
    assign item.cmd         = i_req.cmd;
    assign item.from_node   = i_req.from_node;
    assign item.to_node     = i_req.to_node;
    assign item.edge_weight = i_req.edge_weight;
    assign item.round_count = i_req.round_count;

    rlsp_seq #(.MAX_NODES(MAX_NODES)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_node_cnt   (node_cnt),
        .i_valid      (i_req.valid),
        .o_ready      (i_req.ready),
        .i_item       (item),
        .o_edge_we    (edge_we),
        .o_edge_waddr (edge_waddr),
        .o_edge_wdata (edge_wdata),
        .o_edge_re    (edge_re),
        .o_edge_raddr (edge_raddr),
        .i_edge_rdata (edge_rdata),
        .o_dist_we    (dist_we),
        .o_dist_waddr (dist_waddr),
        .o_dist_wdata (dist_wdata),
        .o_dist_re    (dist_re),
        .o_dist_raddr (dist_raddr),
        .i_dist_rdata (dist_rdata),
        .i_out_free   (out_free),
        .o_res_load   (res_load),
        .o_res        (res)
    );

    // Edge weight matrix, addressed by {tail, head}.
    rlsp_ram #(.ADDR_W(AW), .DATA_W(rlsp_pkg::WEIGHT_W)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_re    (edge_re),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    // Distance table, one entry per node.
    rlsp_ram #(.ADDR_W(NODE_W), .DATA_W(rlsp_pkg::DIST_W)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_re    (dist_re),
        .i_raddr (dist_raddr),
        .o_rdata (dist_rdata)
    );

    // Output register.
    assign out_free = !r_ovld || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (res_load) begin
            r_ovld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid    = r_ovld;
    assign o_rsp.status   = r_out.status;
    assign o_rsp.distance = r_out.distance;

endmodule

`default_nettype wire

// ===== design/rlsp_checker.sv =====
// Port-level checks of the shortest-path block and their binding to the top level.
`default_nettype none

module rlsp_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_req_valid,
    input wire logic                               i_req_ready,
    input wire logic [rlsp_pkg::CMD_W-1:0]         i_req_cmd,
    input wire logic                               i_rsp_valid,
    input wire logic                               i_rsp_ready,
    input wire logic [rlsp_pkg::STATUS_W-1:0]      i_rsp_status,
    input wire logic [rlsp_pkg::DIST_W-1:0]        i_rsp_distance
);

    // Reset starts the clearing pass, so no request is taken right after it.
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> !i_req_ready)
        else $error("request taken right after reset");

    // An insert leaves the block ready again in the next cycle.
    a_insert_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && (i_req_cmd == rlsp_pkg::CMD_INSERT)) |=> i_req_ready)
        else $error("insert did not complete in one cycle");

    // A clear holds off requests while it sweeps the edge memory.
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && (i_req_cmd == rlsp_pkg::CMD_CLEAR)) |=> !i_req_ready)
        else $error("request taken during clear sweep");

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_distance)))
        else $error("stalled result changed");

endmodule

bind round_limited_shortest_path_core rlsp_checker u_rlsp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_req_cmd      (i_req.cmd),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_status   (o_rsp.status),
    .i_rsp_distance (o_rsp.distance)
);

`default_nettype wire

// ===== dv/round_limited_shortest_path_core_test.sv =====
// Self-checking testbench for the round-limited shortest-path core.
module round_limited_shortest_path_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    // The block ignores command code 3.
    localparam logic [rlsp_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CLEAR_DRAIN_CYCLES = 4200;

    typedef enum {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_TOGGLE} t_rx_mode;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_we;
    logic [rlsp_pkg::NODE_COUNT_W-1:0] cfg_data;

    rlsp_req_if req_if();
    rlsp_rsp_if rsp_if();

    round_limited_shortest_path_core u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the graph and of the node count register.
    logic signed [rlsp_pkg::WEIGHT_W-1:0]
        graph_weight [rlsp_pkg::MAX_NODES_DEF*rlsp_pkg::MAX_NODES_DEF];
    logic [rlsp_pkg::NODE_COUNT_W-1:0] model_node_count;
    int                                path_dist [rlsp_pkg::MAX_NODES_DEF];

    rlsp_pkg::t_result pending_results [$];

    int error_count = 0;
    int n_queries   = 0;
    int n_inserts   = 0;
    int n_clears    = 0;
    int n_checked   = 0;
    int n_settings  = 0;
    int burst_left  = 0;
    int rsp_hold_req = 0;
    bit clear_sent  = 1'b1;

    // Builds one request from plain integers.
    function automatic rlsp_pkg::t_item make_request(logic [rlsp_pkg::CMD_W-1:0] cmd,
                                                     int from_node, int to_node,
                                                     int weight, int rounds);
        rlsp_pkg::t_item it;
        it.cmd         = cmd;
        it.from_node   = rlsp_pkg::NODE_FIELD_W'(from_node);
        it.to_node     = rlsp_pkg::NODE_FIELD_W'(to_node);
        it.edge_weight = rlsp_pkg::WEIGHT_W'(weight);
        it.round_count = rlsp_pkg::ROUND_W'(rounds);
        return it;
    endfunction

    // Applies one request to the shadow graph and works out its result, if any.
    function automatic void predict_request(input rlsp_pkg::t_item it, output bit has_res,
                                            output rlsp_pkg::t_result res);
        int n;
        int w;
        int cand;
        n       = (model_node_count > rlsp_pkg::MAX_NODES_DEF) ? rlsp_pkg::MAX_NODES_DEF
                                                                : int'(model_node_count);
        has_res = 1'b0;
        res     = '0;
        case (it.cmd)
            rlsp_pkg::CMD_INSERT: begin
                if (it.from_node < n && it.to_node < n)
                    graph_weight[it.from_node*rlsp_pkg::MAX_NODES_DEF + it.to_node] =
                        it.edge_weight;
            end
            rlsp_pkg::CMD_CLEAR: begin
                foreach (graph_weight[k]) graph_weight[k] = rlsp_pkg::NO_EDGE;
            end
            rlsp_pkg::CMD_QUERY: begin
                has_res = 1'b1;
                if (it.from_node >= n || it.to_node >= n) begin
                    res.status = rlsp_pkg::ST_ABSENT;
                end else begin
                    for (int i = 0; i < n; i++) path_dist[i] = rlsp_pkg::NO_DIST;
                    path_dist[it.from_node] = 0;
                    // In-place relaxation over all ordered pairs, row by row.
                    for (int k = 0; k < it.round_count; k++)
                        for (int i = 0; i < n; i++)
                            for (int j = 0; j < n; j++) begin
                                w = graph_weight[i*rlsp_pkg::MAX_NODES_DEF + j];
                                if (path_dist[i] == rlsp_pkg::NO_DIST ||
                                    w == rlsp_pkg::NO_EDGE) continue;
                                cand = path_dist[i] + w;
                                if (cand > 32767) cand = 32767;
                                else if (cand < -32768) cand = -32768;
                                if (path_dist[j] == rlsp_pkg::NO_DIST || cand < path_dist[j])
                                    path_dist[j] = cand;
                            end
                    if (path_dist[it.to_node] == rlsp_pkg::NO_DIST) begin
                        res.status = rlsp_pkg::ST_UNREACH;
                    end else begin
                        res.status   = rlsp_pkg::ST_OK;
                        res.distance = rlsp_pkg::DIST_W'(path_dist[it.to_node]);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Sends one request in bursts with random gaps, then records its expected result.
    task automatic send_request(input rlsp_pkg::t_item it);
        int                gap;
        bit                has_res;
        rlsp_pkg::t_result res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_if.cmd         <= it.cmd;
        req_if.from_node   <= it.from_node;
        req_if.to_node     <= it.to_node;
        req_if.edge_weight <= it.edge_weight;
        req_if.round_count <= it.round_count;
        req_if.valid       <= 1'b1;
        do @(posedge clk); while (!req_if.ready);
        predict_request(it, has_res, res);
        if (has_res) pending_results.push_back(res);
        case (it.cmd)
            rlsp_pkg::CMD_INSERT: n_inserts++;
            rlsp_pkg::CMD_QUERY:  n_queries++;
            rlsp_pkg::CMD_CLEAR: begin
                n_clears++;
                clear_sent = 1'b1;
            end
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Stops sending, waits for all results, then lets a clearing sweep finish.
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (clear_sent ? CLEAR_DRAIN_CYCLES : 16) @(negedge clk);
        clear_sent = 1'b0;
        burst_left = 0;
    endtask

    // Writes the node count register; only called while the block is idle.
    task automatic write_node_count(input logic [rlsp_pkg::NODE_COUNT_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        model_node_count = value;
        n_settings++;
    endtask

    // Full-size graph: corner nodes, extreme weights, counts of 64 and above.
    task automatic test_full_size();
        wait_idle();
        write_node_count(7'd64);
        send_request(make_request(rlsp_pkg::CMD_QUERY, 0, 0, 0, 0));
        send_request(make_request(rlsp_pkg::CMD_QUERY, 0, 63, 0, 0));
        send_request(make_request(rlsp_pkg::CMD_INSERT, 0, 63, -128, 0));
        send_request(make_request(rlsp_pkg::CMD_INSERT, 63, 0, 127, 0));
        send_request(make_request(rlsp_pkg::CMD_QUERY, 0, 63, 0, 1));
        wait_idle();
        write_node_count(7'd127);
        send_request(make_request(rlsp_pkg::CMD_QUERY, 63, 0, 0, 1));
    endtask

    // Absent nodes, including a node count of zero.
    task automatic test_absent_nodes();
        wait_idle();
        write_node_count(7'd0);
        send_request(make_request(rlsp_pkg::CMD_INSERT, 0, 0, 5, 0));
        send_request(make_request(rlsp_pkg::CMD_QUERY, 0, 0, 0, 1));
        wait_idle();
        write_node_count(7'd1);
        send_request(make_request(rlsp_pkg::CMD_QUERY, 0, 0, 0, 3));
        wait_idle();
        write_node_count(7'd4);
        send_request(make_request(rlsp_pkg::CMD_QUERY, 0, 5, 0, 1));
        send_request(make_request(rlsp_pkg::CMD_QUERY, 9, 1, 0, 1));
        send_request(make_request(rlsp_pkg::CMD_INSERT, 0, 4, 7, 0));
    endtask

    // A distance of exactly 101 reads as unreached, weight 101 removes an edge,
    // zero rounds only reach the source, and code 3 is ignored.
    task automatic test_sentinel_and_rounds();
        send_request(make_request(rlsp_pkg::CMD_INSERT, 0, 1, 100, 0));
        send_request(make_request(rlsp_pkg::CMD_INSERT, 1, 2, 1, 0));
        send_request(make_request(rlsp_pkg::CMD_QUERY, 0, 2, 0, 2));
        send_request(make_request(rlsp_pkg::CMD_QUERY, 0, 1, 0, 1));
        send_request(make_request(rlsp_pkg::CMD_INSERT, 1, 2, rlsp_pkg::NO_EDGE, 0));
        send_request(make_request(CMD_UNUSED, 3, 3, -1, 255));
        send_request(make_request(rlsp_pkg::CMD_QUERY, 0, 2, 0, 3));
        send_request(make_request(rlsp_pkg::CMD_QUERY, 2, 2, 0, 0));
        send_request(make_request(rlsp_pkg::CMD_QUERY, 0, 1, 0, 0));
    endtask

    // A strongly negative cycle over 255 rounds drives the sum to saturation.
    task automatic test_saturation();
        wait_idle();
        write_node_count(7'd2);
        send_request(make_request(rlsp_pkg::CMD_INSERT, 0, 1, -128, 0));
        send_request(make_request(rlsp_pkg::CMD_INSERT, 1, 0, -128, 0));
        send_request(make_request(rlsp_pkg::CMD_QUERY, 0, 0, 0, 255));
        send_request(make_request(rlsp_pkg::CMD_QUERY, 1, 0, 0, 255));
    endtask

    // Clearing removes every edge.
    task automatic test_clear();
        send_request(make_request(rlsp_pkg::CMD_CLEAR, 0, 0, 0, 0));
        send_request(make_request(rlsp_pkg::CMD_QUERY, 0, 1, 0, 1));
    endtask

    // Random graphs over several small node counts, with some noise mixed in.
    task automatic test_random_graphs();
        int counted;
        int n;
        int r;
        int a;
        int b;
        int sel;
        int rounds;
        int weight;
        counted = 0;
        while (counted < 80) begin
            n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
            wait_idle();
            write_node_count(rlsp_pkg::NODE_COUNT_W'(n));
            repeat ($urandom_range(20, 32)) begin
                r = $urandom_range(0, 99);
                a = $urandom_range(0, n - 1);
                b = $urandom_range(0, n - 1);
                if (r >= 80 && r < 95) begin
                    a = $urandom_range(0, 63);
                    b = $urandom_range(0, 63);
                end
                // Long round counts only where the graph is tiny.
                if (n <= 4 && $urandom_range(0, 7) == 0) rounds = $urandom_range(0, 255);
                else rounds = $urandom_range(0, n + 2);
                sel = $urandom_range(0, 19);
                if (sel < 14) weight = int'($urandom_range(0, 70)) - 10;
                else if (sel < 18) weight = $urandom_range(0, 255);
                else weight = rlsp_pkg::NO_EDGE;
                if (r < 45 || (r >= 80 && r < 88)) begin
                    send_request(make_request(rlsp_pkg::CMD_INSERT, a, b, weight, rounds));
                    if (a < n && b < n) counted++;
                end else if (r < 95) begin
                    send_request(make_request(rlsp_pkg::CMD_QUERY, a, b, weight, rounds));
                    counted++;
                end else if (r < 97) begin
                    send_request(make_request(rlsp_pkg::CMD_CLEAR, a, b, weight, rounds));
                    counted++;
                end else begin
                    send_request(make_request(CMD_UNUSED, a, b, weight, rounds));
                end
            end
        end
    endtask

    // Long receiver hold-off fills the block, then a full pause of the sender.
    task automatic test_backpressure();
        wait_idle();
        write_node_count(7'd3);
        send_request(make_request(rlsp_pkg::CMD_INSERT, 0, 1, 5, 0));
        send_request(make_request(rlsp_pkg::CMD_INSERT, 1, 2, -3, 0));
        send_request(make_request(rlsp_pkg::CMD_INSERT, 2, 0, 4, 0));
        rsp_hold_req = 3000;
        repeat (8)
            send_request(make_request(rlsp_pkg::CMD_QUERY, $urandom_range(0, 2),
                                      $urandom_range(0, 2), 0, $urandom_range(1, 3)));
        wait_idle();
        repeat (4)
            send_request(make_request(rlsp_pkg::CMD_QUERY, $urandom_range(0, 2),
                                      $urandom_range(0, 2), 0, $urandom_range(0, 3)));
    endtask

    // Receiver ready pattern; a requested hold-off is counted down here.
    initial begin : rsp_ready_gen
        int       hold_left;
        int       mode_left;
        t_rx_mode mode;
        hold_left = 0;
        mode_left = 0;
        mode      = RX_ALWAYS;
        forever begin
            @(negedge clk);
            if (rsp_hold_req > 0) begin
                hold_left    = rsp_hold_req;
                rsp_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS: rsp_if.ready <= 1'b1;
                    RX_MOSTLY: rsp_if.ready <= ($urandom_range(0, 3) != 0);
                    RX_RARELY: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    default:   rsp_if.ready <= ~rsp_if.ready;
                endcase
            end
        end
    end

    // Compares each accepted result with the oldest expected one.
    always @(posedge clk) begin
        rlsp_pkg::t_result exp_res;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d distance %0d", $time,
                         rsp_if.status, rsp_if.distance);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                n_checked++;
                if (rsp_if.status !== exp_res.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                             exp_res.status, rsp_if.status);
                    error_count++;
                end
                if (rsp_if.distance !== exp_res.distance) begin
                    $display("%0t: distance mismatch, expected %0d, actual %0d", $time,
                             exp_res.distance, rsp_if.distance);
                    error_count++;
                end
            end
        end
    end

    // Hard limit on the run time.
    initial begin
        #50000000;
        $display("%0t: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int waited;
        foreach (graph_weight[k]) graph_weight[k] = rlsp_pkg::NO_EDGE;
        model_node_count   = rlsp_pkg::NODE_COUNT_RST;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_data           = '0;
        req_if.valid       = 1'b0;
        req_if.cmd         = rlsp_pkg::CMD_INSERT;
        req_if.from_node   = '0;
        req_if.to_node     = '0;
        req_if.edge_weight = '0;
        req_if.round_count = '0;
        rsp_if.ready       = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_full_size();
        test_absent_nodes();
        test_sentinel_and_rounds();
        test_saturation();
        test_clear();
        test_random_graphs();
        test_backpressure();

        // Drain the remaining results, then allow any clearing sweep to end.
        req_if.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 200000) begin
            @(negedge clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
            error_count += pending_results.size();
        end
        repeat (clear_sent ? CLEAR_DRAIN_CYCLES : 32) @(negedge clk);

        $display("Sent %0d queries, %0d inserts and %0d clears over %0d node-count settings.",
                 n_queries, n_inserts, n_clears, n_settings);
        $display("Checked %0d results, %0d mismatches seen.", n_checked, error_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rlsp_pkg.sv
design/rlsp_intf.sv
design/rlsp_ram.sv
design/rlsp_seq.sv
design/round_limited_shortest_path_core.sv
design/rlsp_checker.sv
dv/round_limited_shortest_path_core_test.sv
